/* hdl/bed_pkg.sv */
// ----------------------------------------------------------------------------
// bed_pkg
// Shared sizes, function codes and types of the banded edit distance unit.
// ----------------------------------------------------------------------------
package bed_pkg;

    localparam int MAX_LEN   = 64;
    localparam int MAX_K     = 8;

    localparam int CHAR_W    = 8;
    localparam int FUNC_W    = 2;
    localparam int CFG_W     = 4;
    localparam int DIST_W    = 4;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int ADDR_W    = $clog2(MAX_LEN);
    localparam int NUM_CELLS = 2 * MAX_K + 1;
    localparam int CIDX_W    = $clog2(NUM_CELLS);
    // band values saturate at k+1, a step adds one more
    localparam int VAL_W     = $clog2(MAX_K + 3);
    // last step index is len1 + len2 + MAX_K
    localparam int STEP_W    = $clog2(2 * MAX_LEN + MAX_K + 1);

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

    typedef logic [FUNC_W-1:0] t_func;

    localparam t_func FUNC_APPEND_FIRST  = 2'd0;
    localparam t_func FUNC_APPEND_SECOND = 2'd1;
    localparam t_func FUNC_COMPARE       = 2'd2;

    typedef struct packed {
        logic              load;
        logic              active;
        logic [VAL_W-1:0]  cap;
    } t_cell_ctl;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              over_threshold;
        logic              length_overflow;
    } t_res;

endpackage

/* hdl/bed_if.sv */
// ----------------------------------------------------------------------------
// bed_if
// Request and result channels (valid/ready) of the edit distance unit.
// ----------------------------------------------------------------------------
interface bed_req_if;
    import bed_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;

    modport source (output valid, output func, output char_code, input ready);
    modport sink   (input valid, input func, input char_code, output ready);
endinterface

interface bed_res_if;
    import bed_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              over_threshold;
    logic              length_overflow;

    modport source (output valid, output distance, output over_threshold,
                    output length_overflow, input ready);
    modport sink   (input valid, input distance, input over_threshold,
                    input length_overflow, output ready);
endinterface

/* hdl/banded_edit_distance_threshold_unit.sv */
// ----------------------------------------------------------------------------
// banded_edit_distance_threshold_unit
// Thresholded Levenshtein distance of two byte strings on a systolic band.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request: func 0 appends char_code to the first string,
//   func 1 to the second, func 2 compares the two and clears them, func 3 is
//   dropped. o_res returns one result per compare request.
//   i_cfg_wr_en / i_cfg_wr_data write max_distance (the limit k, reset 1);
//   write it only while no compare is in flight. k is clipped to MAX_K.
//   A character past MAX_LEN is dropped and reported as length_overflow on
//   the next result.
//   A compare steps the band from step 0 to len1 + len2 + MAX_K, then
//   registers the result in the output register from the done state. A pair
//   whose lengths differ by more than k is rejected at once: it skips the
//   band and goes straight to the done state.
//   i_req.ready is low while a compare is in progress. Appends are still
//   taken while a result waits on a stalled o_res; a new compare then holds
//   its result until the output register is free.
//   Reset (synchronous, active low) empties both strings, clears the
//   overflow flag and the output valid, and sets k to 1.
// ----------------------------------------------------------------------------
module banded_edit_distance_threshold_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [bed_pkg::CFG_W-1:0] i_cfg_wr_data,
    bed_req_if.sink                   i_req,
    bed_res_if.source                 o_res
);
    import bed_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state             r_state,   n_state;
    logic [CFG_W-1:0]   r_max_dist, n_max_dist;
    logic [LEN_W-1:0]   r_len_a,   n_len_a;
    logic [LEN_W-1:0]   r_len_b,   n_len_b;
    logic               r_ovf,     n_ovf;
    logic [STEP_W-1:0]  r_step,    n_step;
    logic [STEP_W-1:0]  r_send,    n_send;
    logic [CIDX_W-1:0]  r_cstar,   n_cstar;
    logic               r_reject,  n_reject;
    logic               r_out_vld, n_out_vld;
    t_res               r_out,     n_out;

    logic [VAL_W-1:0]   w_k;
    logic [VAL_W-1:0]   w_cap;
    logic               w_req_acc;
    logic               w_cmp_acc;
    logic               w_wr_a;
    logic               w_wr_b;
    logic [LEN_W-1:0]   w_diff;
    logic [STEP_W-1:0]  w_step_m1;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [CHAR_W-1:0]  w_q_a;
    logic [CHAR_W-1:0]  w_q_b;
    logic               w_handoff;
    logic [VAL_W-1:0]   w_final;

    logic [CHAR_W-1:0]  w_a_out [NUM_CELLS];
    logic [CHAR_W-1:0]  w_b_out [NUM_CELLS];
    logic [VAL_W-1:0]   w_val   [NUM_CELLS];

    // effective limit and the saturation value of the band
    assign w_k   = (r_max_dist > CFG_W'(MAX_K)) ? VAL_W'(MAX_K) : VAL_W'(r_max_dist);
    assign w_cap = w_k + VAL_W'(1);

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_cmp_acc   = w_req_acc && (i_req.func == FUNC_COMPARE);
    assign w_wr_a      = w_req_acc && (i_req.func == FUNC_APPEND_FIRST)
                         && (r_len_a < LEN_W'(MAX_LEN));
    assign w_wr_b      = w_req_acc && (i_req.func == FUNC_APPEND_SECOND)
                         && (r_len_b < LEN_W'(MAX_LEN));

    assign w_diff = (r_len_a > r_len_b) ? r_len_a - r_len_b : r_len_b - r_len_a;

    // Step s is anti-diagonal t = s - MAX_K. Both strings are read at the
    // same index: the bottom cell consumes the first string, the top cell
    // the second; the read address at step s is (s - 1) / 2.
    assign w_step_m1 = r_step - STEP_W'(1);
    assign w_rd_addr = w_step_m1[ADDR_W:1];

    bed_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_a),
        .i_wr_addr (r_len_a[ADDR_W-1:0]),
        .i_wr_data (i_req.char_code),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_q_a)
    );

    bed_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_b),
        .i_wr_addr (r_len_b[ADDR_W-1:0]),
        .i_wr_data (i_req.char_code),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_q_b)
    );

    // Cell c works on diagonal d = c - MAX_K. It starts at |d| (the matrix
    // border, clipped to k + 1) and updates on steps of its own parity once
    // row and column are both past zero. First-string characters climb the
    // chain, second-string characters descend it.
    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        localparam int OFFS  = (c >= MAX_K) ? c - MAX_K : MAX_K - c;
        localparam int START = OFFS + MAX_K + 2;
        localparam bit PAR   = (c % 2) != 0;

        t_cell_ctl         w_ctl;
        logic [VAL_W-1:0]  w_init;
        logic [CHAR_W-1:0] w_a_in;
        logic [CHAR_W-1:0] w_b_in;
        logic [VAL_W-1:0]  w_up;
        logic [VAL_W-1:0]  w_dn;

        assign w_init       = (VAL_W'(OFFS) > w_cap) ? w_cap : VAL_W'(OFFS);
        assign w_ctl.load   = w_cmp_acc;
        assign w_ctl.active = (r_state == ST_RUN) && (r_step[0] == PAR)
                              && (r_step >= STEP_W'(START));
        assign w_ctl.cap    = w_cap;

        if (c == 0) begin : g_lo
            assign w_a_in = w_q_a;
            assign w_dn   = w_cap;
        end else begin : g_lo_n
            assign w_a_in = w_a_out[c-1];
            assign w_dn   = w_val[c-1];
        end

        if (c == NUM_CELLS - 1) begin : g_hi
            assign w_b_in = w_q_b;
            assign w_up   = w_cap;
        end else begin : g_hi_n
            assign w_b_in = w_b_out[c+1];
            assign w_up   = w_val[c+1];
        end

        bed_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (w_ctl),
            .i_init (w_init),
            .i_a    (w_a_in),
            .i_b    (w_b_in),
            .i_up   (w_up),
            .i_down (w_dn),
            .o_a    (w_a_out[c]),
            .o_b    (w_b_out[c]),
            .o_val  (w_val[c])
        );
    end

    assign w_final   = w_val[r_cstar];
    assign w_handoff = (r_state == ST_DONE) && (!r_out_vld || o_res.ready);

    always_comb begin
        n_state    = r_state;
        n_max_dist = r_max_dist;
        n_len_a    = r_len_a;
        n_len_b    = r_len_b;
        n_ovf      = r_ovf;
        n_step     = r_step;
        n_send     = r_send;
        n_cstar    = r_cstar;
        n_reject   = r_reject;
        n_out_vld  = r_out_vld;
        n_out      = r_out;

        if (i_cfg_wr_en) begin
            n_max_dist = i_cfg_wr_data;
        end

        if (r_out_vld && o_res.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_req_acc) begin
                    case (i_req.func)
                        FUNC_APPEND_FIRST: begin
                            if (w_wr_a) begin
                                n_len_a = r_len_a + LEN_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        FUNC_APPEND_SECOND: begin
                            if (w_wr_b) begin
                                n_len_b = r_len_b + LEN_W'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        FUNC_COMPARE: begin
                            n_step   = '0;
                            n_send   = STEP_W'(r_len_a) + STEP_W'(r_len_b)
                                       + STEP_W'(MAX_K);
                            n_cstar  = CIDX_W'(STEP_W'(r_len_b) + STEP_W'(MAX_K)
                                       - STEP_W'(r_len_a));
                            n_reject = (w_diff > LEN_W'(w_k));
                            n_state  = (w_diff > LEN_W'(w_k)) ? ST_DONE : ST_RUN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == r_send) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_handoff) begin
                    n_out_vld = 1'b1;
                    if (r_reject || (w_final > w_k)) begin
                        n_out.distance       = '0;
                        n_out.over_threshold = 1'b1;
                    end else begin
                        n_out.distance       = DIST_W'(w_final);
                        n_out.over_threshold = 1'b0;
                    end
                    n_out.length_overflow = r_ovf;
                    n_len_a = '0;
                    n_len_b = '0;
                    n_ovf   = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_max_dist <= CFG_RESET;
            r_len_a    <= '0;
            r_len_b    <= '0;
            r_ovf      <= 1'b0;
            r_step     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_max_dist <= n_max_dist;
            r_len_a    <= n_len_a;
            r_len_b    <= n_len_b;
            r_ovf      <= n_ovf;
            r_step     <= n_step;
            r_out_vld  <= n_out_vld;
        end
    end

    // payload of the compare in flight and of the output register
    always_ff @(posedge i_clk) begin
        r_send   <= n_send;
        r_cstar  <= n_cstar;
        r_reject <= n_reject;
        r_out    <= n_out;
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.distance        = r_out.distance;
    assign o_res.over_threshold  = r_out.over_threshold;
    assign o_res.length_overflow = r_out.length_overflow;
endmodule

/* hdl/bed_ram.sv */
// ----------------------------------------------------------------------------
// bed_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

/* hdl/bed_cell.sv */
// ----------------------------------------------------------------------------
// bed_cell
// One diagonal of the band: holds its DP value, passes characters along.
// ----------------------------------------------------------------------------
module bed_cell (
    input  logic                       i_clk,
    input  bed_pkg::t_cell_ctl         i_ctl,
    input  logic [bed_pkg::VAL_W-1:0]  i_init,
    input  logic [bed_pkg::CHAR_W-1:0] i_a,
    input  logic [bed_pkg::CHAR_W-1:0] i_b,
    input  logic [bed_pkg::VAL_W-1:0]  i_up,
    input  logic [bed_pkg::VAL_W-1:0]  i_down,
    output logic [bed_pkg::CHAR_W-1:0] o_a,
    output logic [bed_pkg::CHAR_W-1:0] o_b,
    output logic [bed_pkg::VAL_W-1:0]  o_val
);
    import bed_pkg::*;

    logic [CHAR_W-1:0] r_a;
    logic [CHAR_W-1:0] r_b;
    logic [VAL_W-1:0]  r_val;
    logic [VAL_W-1:0]  n_val;
    logic [VAL_W-1:0]  w_sub;
    logic [VAL_W-1:0]  w_gap;
    logic [VAL_W-1:0]  w_best;

    // diagonal (substitute/match) against the two gap moves, clipped at cap
    always_comb begin
        w_sub  = r_val + ((i_a != i_b) ? VAL_W'(1) : VAL_W'(0));
        w_gap  = (i_up < i_down) ? i_up + VAL_W'(1) : i_down + VAL_W'(1);
        w_best = (w_sub < w_gap) ? w_sub : w_gap;
        if (w_best > i_ctl.cap) begin
            w_best = i_ctl.cap;
        end
        if (i_ctl.load) begin
            n_val = i_init;
        end else if (i_ctl.active) begin
            n_val = w_best;
        end else begin
            n_val = r_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= i_a;
        r_b   <= i_b;
        r_val <= n_val;
    end

    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_val = r_val;
endmodule
